// File: src/n2a_pkg.sv
// Shared types, constants and helpers for the number to ASCII formatter.
package n2a_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned CharW  = 7;
  localparam int unsigned NumDec = 5;   // decimal digits of a 16-bit value
  localparam int unsigned NumHex = 4;   // hex digits of a 16-bit value
  localparam int unsigned NumSub = 4;   // subtraction stages (10^4 down to 10)
  localparam int unsigned MaxChr = 6;   // "0x" plus four hex digits
  localparam int unsigned LenW   = 3;
  localparam int unsigned ThrW   = 17;  // 9 * 10000 does not fit in 16 bits

  // format modes on func
  localparam logic FuncDec = 1'b0;
  localparam logic FuncHex = 1'b1;

  localparam logic [CharW-1:0] ChrZero = 7'h30;
  localparam logic [CharW-1:0] ChrX    = 7'h78;
  localparam logic [CharW-1:0] ChrA    = 7'h41;

  // multiples 0..9 of the place weight of each subtraction stage
  localparam logic [ThrW-1:0] Thr [NumSub][10] = '{
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
      17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
      17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
      17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
      17'd50, 17'd60, 17'd70, 17'd80, 17'd90}
  };

  // word moving down the subtraction pipeline
  typedef struct packed {
    logic [ValueW-1:0]       value;
    logic                    func;
    logic [ValueW-1:0]       rem;
    logic [NumSub-1:0][3:0]  dig;   // dig[0] is the ten-thousands digit
  } n2a_bcd_t;

  // formatted text, chars[0] leaves first
  typedef struct packed {
    logic [MaxChr-1:0][CharW-1:0] chars;
    logic [LenW-1:0]              len;
  } n2a_text_t;

  function automatic logic [CharW-1:0] hex_glyph(input logic [3:0] nib);
    logic [CharW-1:0] g;
    if (nib < 4'd10) begin
      g = ChrZero + CharW'(nib);
    end else begin
      g = ChrA + CharW'(nib - 4'd10);
    end
    return g;
  endfunction

endpackage

// File: src/n2a_sub_pipe.sv
// Decimal digit extraction by repeated subtraction, one place per stage.
module n2a_sub_pipe (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  n2a_pkg::n2a_bcd_t up_word_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output n2a_pkg::n2a_bcd_t dn_word_o
);
  import n2a_pkg::*;

  logic     [NumSub-1:0] valid_q;
  logic     [NumSub:0]   rdy;
  n2a_bcd_t              word_q [NumSub];

  assign rdy[NumSub] = dn_ready_i;

  for (genvar s = 0; s < NumSub; s++) begin : g_stage
    n2a_bcd_t   src;
    logic       src_valid;
    n2a_bcd_t   word_d;
    logic [3:0] dig;

    if (s == 0) begin : g_first
      assign src       = up_word_i;
      assign src_valid = up_valid_i;
    end else begin : g_next
      assign src       = word_q[s-1];
      assign src_valid = valid_q[s-1];
    end

    assign rdy[s] = !valid_q[s] || rdy[s+1];

    // compares are monotone in k, so the last one that holds is the digit
    always_comb begin
      dig = 4'd0;
      for (int k = 1; k < 10; k++) begin
        if ({1'b0, src.rem} >= Thr[s][k]) begin
          dig = 4'(k);
        end
      end
      word_d        = src;
      word_d.dig[s] = dig;
      word_d.rem    = ValueW'({1'b0, src.rem} - Thr[s][dig]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && src_valid) begin
        word_q[s] <= word_d;
      end
    end
  end

  assign up_ready_o = rdy[0];
  assign dn_valid_o = valid_q[NumSub-1];
  assign dn_word_o  = word_q[NumSub-1];

endmodule

// File: src/n2a_format.sv
// Leading zero suppression and character assembly, one register stage.
module n2a_format (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  n2a_pkg::n2a_bcd_t  up_word_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output n2a_pkg::n2a_text_t dn_text_o
);
  import n2a_pkg::*;

  logic      valid_q;
  n2a_text_t text_q;
  n2a_text_t text_d;

  always_comb begin
    logic [NumDec-1:0][3:0] dd;
    logic [NumHex-1:0][3:0] hh;
    int                     nd;
    int                     nh;
    int                     idx;
    // dd[0] and hh[0] are the most significant digits
    dd = {up_word_i.rem[3:0], up_word_i.dig[3], up_word_i.dig[2],
          up_word_i.dig[1], up_word_i.dig[0]};
    hh = {up_word_i.value[3:0], up_word_i.value[7:4],
          up_word_i.value[11:8], up_word_i.value[15:12]};
    nd = 1;
    for (int i = NumDec - 1; i >= 1; i--) begin
      if (dd[NumDec-1-i] != 4'd0 && nd == 1) begin
        nd = i + 1;
      end
    end
    nh = 1;
    for (int i = NumHex - 1; i >= 1; i--) begin
      if (hh[NumHex-1-i] != 4'd0 && nh == 1) begin
        nh = i + 1;
      end
    end
    text_d.chars = '0;
    if (up_word_i.func == FuncHex) begin
      text_d.chars[0] = ChrZero;
      text_d.chars[1] = ChrX;
      for (int i = 0; i < NumHex; i++) begin
        idx = NumHex - nh + i;
        if (idx < NumHex) begin
          text_d.chars[i+2] = hex_glyph(hh[idx[1:0]]);
        end
      end
      text_d.len = LenW'(nh + 2);
    end else begin
      for (int i = 0; i < NumDec; i++) begin
        idx = NumDec - nd + i;
        if (idx < NumDec) begin
          text_d.chars[i] = ChrZero + CharW'(dd[idx[2:0]]);
        end
      end
      text_d.len = LenW'(nd);
    end
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      text_q <= text_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_text_o  = text_q;

endmodule

// File: src/n2a_serial.sv
// Character serialiser: holds one formatted number and sends a character a word.
module n2a_serial (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         up_valid_i,
  output logic                         up_ready_o,
  input  n2a_pkg::n2a_text_t            up_text_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [n2a_pkg::CharW-1:0]    ascii_char_o,
  output logic                         last_o
);
  import n2a_pkg::*;

  logic            busy_q;
  logic [LenW-1:0] pos_q;
  n2a_text_t       text_q;
  logic            fire;
  logic            load;

  assign last_o       = (pos_q == text_q.len - LenW'(1));
  assign ascii_char_o = text_q.chars[pos_q];
  assign out_valid_o  = busy_q;
  assign fire         = busy_q && out_ready_i;
  // next number loads as the last character of this one goes
  assign up_ready_o   = !busy_q || (out_ready_i && last_o);
  assign load         = up_valid_i && up_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
    end else if (fire) begin
      if (last_o) begin
        busy_q <= 1'b0;
        pos_q  <= '0;
      end else begin
        pos_q <= pos_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      text_q <= up_text_i;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q < text_q.len))
    else $error("character index beyond text length");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (text_q.len >= LenW'(1) && text_q.len <= LenW'(MaxChr)))
    else $error("text length out of range");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last_o) |=> (busy_q && pos_q == $past(pos_q) + LenW'(1)))
    else $error("character index did not advance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_ready_i) |=> (busy_q && $stable(pos_q)))
    else $error("stalled character lost");
`endif

endmodule

// File: src/number_to_ascii_formatter.sv
// Top level of the number to ASCII formatter.
//
// Input channel: value_i (16 bit) and func_i (0 decimal, 1 hex with "0x"),
// taken when in_valid_i and in_ready_o are high at a clock edge.
// Output channel: one ASCII character a word on ascii_char_o, with last_o
// high on the final character of each number; taken on out_valid_o and
// out_ready_i. Decimal gives 1 to 5 characters, hex 3 to 6, no leading zeros.
// Path: the first character of a number becomes valid once the word has
// passed every register (the first subtraction stage loads at the edge that
// accepts it, then three more subtraction stages, one format stage and the
// serialiser load). Throughput: a number holds the serialiser until its last
// character is taken; the pipeline ahead accepts a new number every cycle
// until it fills.
// Reset empties every stage; nothing else is kept between numbers.
// A receiver stall holds the current character; the pipeline fills behind it
// and in_ready_o falls once all stages hold a word.
module number_to_ascii_formatter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [n2a_pkg::ValueW-1:0] value_i,
  input  logic                      func_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [n2a_pkg::CharW-1:0]  ascii_char_o,
  output logic                      last_o
);
  import n2a_pkg::*;

  n2a_bcd_t  in_word;
  n2a_bcd_t  sub_word;
  n2a_text_t fmt_text;
  logic      sub_valid;
  logic      sub_ready;
  logic      fmt_valid;
  logic      fmt_ready;

  always_comb begin
    in_word       = '0;
    in_word.value = value_i;
    in_word.func  = func_i;
    in_word.rem   = value_i;
  end

  n2a_sub_pipe u_sub (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .up_word_i  (in_word),
    .dn_valid_o (sub_valid),
    .dn_ready_i (sub_ready),
    .dn_word_o  (sub_word)
  );

  n2a_format u_fmt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (sub_valid),
    .up_ready_o (sub_ready),
    .up_word_i  (sub_word),
    .dn_valid_o (fmt_valid),
    .dn_ready_i (fmt_ready),
    .dn_text_o  (fmt_text)
  );

  n2a_serial u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (fmt_valid),
    .up_ready_o   (fmt_ready),
    .up_text_i    (fmt_text),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule

// File: tb/number_to_ascii_formatter_tb.sv
// Self-checking testbench for the number to ASCII formatter, with a character scoreboard.
`timescale 1ns / 100ps

module number_to_ascii_formatter_tb;
  import n2a_pkg::*;

  localparam int unsigned RandomItems = 336;
  localparam int unsigned PressureItems = 40;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned WatchdogLimit = 3000;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } char_word_t;

  class text_scoreboard;
    char_word_t  expected_q[$];
    int unsigned fails;
    int unsigned chars_checked;
    int unsigned dec_numbers;
    int unsigned hex_numbers;
    string       hex_set;

    function new();
      fails = 0;
      chars_checked = 0;
      dec_numbers = 0;
      hex_numbers = 0;
      hex_set = "0123456789ABCDEF";
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fails++;
    endtask

    // Expands one accepted number into the characters it must produce.
    function void note_number(input logic [ValueW-1:0] value, input logic func);
      logic [CharW-1:0] glyphs[$];
      int unsigned      rest;
      char_word_t       w;
      rest = value;
      if (func == FuncHex) begin
        hex_numbers++;
        do begin
          glyphs.push_front(CharW'(hex_set[rest % 16]));
          rest = rest / 16;
        end while (rest != 0);
        w.ch = ChrZero;
        w.last = 1'b0;
        expected_q.push_back(w);
        w.ch = ChrX;
        expected_q.push_back(w);
      end else begin
        dec_numbers++;
        do begin
          glyphs.push_front(ChrZero + CharW'(rest % 10));
          rest = rest / 10;
        end while (rest != 0);
      end
      foreach (glyphs[i]) begin
        w.ch = glyphs[i];
        w.last = (i == glyphs.size() - 1);
        expected_q.push_back(w);
      end
    endfunction

    task check_char(input logic [CharW-1:0] ch, input logic last);
      char_word_t w;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
      end else begin
        w = expected_q.pop_front();
        chars_checked++;
        if (ch !== w.ch) begin
          report_mismatch($sformatf("char 0x%02h, expected 0x%02h", ch, w.ch));
        end
        if (last !== w.last) begin
          report_mismatch($sformatf("last %0b on char 0x%02h, expected %0b", last, ch, w.last));
        end
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ValueW-1:0]   value_i;
  logic                func_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CharW-1:0]    ascii_char_o;
  logic                last_o;

  int unsigned    sender_idle_pct;
  int unsigned    recv_stall_pct;
  logic           hold_off;
  logic           pressure_req;
  int unsigned    quiet_cycles;
  text_scoreboard board;

  number_to_ascii_formatter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .func_i       (func_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Output side: check every accepted word, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_char(ascii_char_o, last_o);
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Long output hold-off, timed here so the sender keeps pushing meanwhile.
  initial begin
    wait (pressure_req === 1'b1);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no word moved for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_number(input logic [ValueW-1:0] v, input logic f);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    func_i     <= f;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_number(v, f);
  endtask

  // Mix of full-range, short, boundary and tiny values so every digit count shows up.
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] edges[16];
    logic [ValueW-1:0] v;
    edges = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999,
              16'd10000, 16'd15, 16'd16, 16'd255, 16'd256, 16'd4095, 16'd4096, 16'hFFFF};
    case ($urandom_range(0, 3))
      0: v = ValueW'($urandom);
      1: v = ValueW'($urandom & ((32'd1 << $urandom_range(1, 16)) - 1));
      2: v = edges[$urandom_range(0, 15)];
      default: v = ValueW'($urandom_range(0, 15));
    endcase
    return v;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_number(pick_value(), 1'($urandom));
  endtask

  initial begin
    logic [ValueW-1:0] directed[12];
    directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd15, 16'd16, 16'd255, 16'd4096,
                 16'd9999, 16'd10000, 16'hAAAA, 16'hFFFF};
    board = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    value_i = '0;
    func_i = FuncDec;
    out_ready_i = 1'b0;
    hold_off = 1'b0;
    pressure_req = 1'b0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_number(directed[i], FuncDec);
      send_number(directed[i], FuncHex);
    end

    run_random(RandomItems / 4);
    sender_idle_pct = 67;
    run_random(RandomItems / 4);
    sender_idle_pct = 0;
    recv_stall_pct = 67;
    run_random(RandomItems / 4);
    sender_idle_pct = 22;
    recv_stall_pct = 22;
    run_random(RandomItems / 4);

    // fill the pipeline against a stopped output
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_req <= 1'b1;
    run_random(PressureItems);

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Formatted %0d decimal and %0d hex numbers, %0d characters checked,",
             board.dec_numbers, board.hex_numbers, board.chars_checked);
    $display("across idle, sender-gap, receiver-stall and mixed phases plus a long output hold-off");
    if (board.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", board.fails);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
src/n2a_pkg.sv
src/n2a_sub_pipe.sv
src/n2a_format.sv
src/n2a_serial.sv
src/number_to_ascii_formatter.sv
tb/number_to_ascii_formatter_tb.sv
